>>> rtl/sbd_pkg.sv
// shared types, constants and round functions for the 24-bit spn block decrypter
`default_nettype none

package sbd_pkg;

    localparam int BLOCK_W     = 24;
    localparam int KEY_INDEX_W = 4;
    localparam int NIBBLES     = BLOCK_W / 4;

    // item command codes
    localparam logic CMD_LOAD_KEY = 1'b0;
    localparam logic CMD_DECRYPT  = 1'b1;

    typedef logic [BLOCK_W-1:0] t_block;

    // controller to datapath commands, at most one set per cycle
    typedef struct packed {
        logic cap_ct;     // take the ciphertext of the accepted item
        logic whiten;     // xor with the last round key
        logic step;       // one inverse round into the block register
        logic out_round;  // last inverse round straight into the output register
        logic out_hold;   // finished block into the output register
    } t_dp_cmd;

    localparam logic [3:0] INV_SBOX [16] = '{
        4'h5, 4'he, 4'hf, 4'h8, 4'hc, 4'h1, 4'h2, 4'hd,
        4'hb, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'ha
    };

    // output bit j takes input bit 6*(j mod 4) + j/4
    function automatic t_block inv_permute(input t_block s);
        t_block t;
        for (int j = 0; j < BLOCK_W; j++) begin
            t[j] = s[6 * (j % 4) + j / 4];
        end
        return t;
    endfunction

    function automatic t_block inv_substitute(input t_block s);
        t_block t;
        for (int n = 0; n < NIBBLES; n++) begin
            t[4*n +: 4] = INV_SBOX[s[4*n +: 4]];
        end
        return t;
    endfunction

    // round without the key xor
    function automatic t_block inv_round(input t_block s);
        return inv_substitute(inv_permute(s));
    endfunction

endpackage

`default_nettype wire

>>> rtl/sbd_in_if.sv
// input channel: command items with key load and ciphertext payload
`default_nettype none

interface sbd_in_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic [sbd_pkg::KEY_INDEX_W-1:0]     key_index;
    logic [sbd_pkg::BLOCK_W-1:0]         key_value;
    logic [sbd_pkg::BLOCK_W-1:0]         ciphertext;

    modport source (output valid, command, key_index, key_value, ciphertext, input ready);
    modport sink   (input valid, command, key_index, key_value, ciphertext, output ready);
endinterface

`default_nettype wire

>>> rtl/sbd_out_if.sv
// output channel: decrypted block items
`default_nettype none

interface sbd_out_if;
    logic                          valid;
    logic                          ready;
    logic [sbd_pkg::BLOCK_W-1:0]   plaintext;

    modport source (output valid, plaintext, input ready);
    modport sink   (input valid, plaintext, output ready);
endinterface

`default_nettype wire

>>> rtl/sbd_ram.sv
// generic single write port ram with registered read
`default_nettype none

module sbd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 11,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/sbd_ctrl.sv
// controller: item handshake, key store addressing and round sequencing
`default_nettype none

module sbd_ctrl #(
    parameter int NUM_ROUNDS = 10,
    localparam int AW = $clog2(NUM_ROUNDS + 1)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_command,
    input  wire logic [sbd_pkg::KEY_INDEX_W-1:0]   i_key_index,
    output logic                                   o_in_ready,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_wr_en,
    output logic      [AW-1:0]                     o_wr_addr,
    output logic      [AW-1:0]                     o_rd_addr,
    output sbd_pkg::t_dp_cmd                       o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WHITEN = 2'd1;
    localparam logic [1:0] S_ROUND  = 2'd2;
    localparam logic [1:0] S_HOLD   = 2'd3;

    localparam logic [AW-1:0] LAST_KEY = AW'(NUM_ROUNDS);
    localparam logic [AW-1:0] PREV_KEY = AW'(NUM_ROUNDS - 1);

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          out_free;
    logic          key_in_range;
    logic [31:0]   key_index_ext;

    assign key_index_ext = 32'(i_key_index);
    assign key_in_range  = (key_index_ext < 32'(NUM_ROUNDS + 1));
    assign o_wr_addr     = key_index_ext[AW-1:0];
    assign out_free      = !r_out_valid || i_out_ready;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_wr_en     = 1'b0;
        o_rd_addr   = LAST_KEY;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_rd_addr = LAST_KEY;
                if (i_in_valid) begin
                    if (i_in_command == sbd_pkg::CMD_DECRYPT) begin
                        o_cmd.cap_ct = 1'b1;
                        n_state      = S_WHITEN;
                    end else begin
                        o_wr_en = key_in_range;
                    end
                end
            end
            S_WHITEN: begin
                o_rd_addr    = PREV_KEY;
                o_cmd.whiten = 1'b1;
                n_cnt        = PREV_KEY;
                n_state      = S_ROUND;
            end
            S_ROUND: begin
                o_rd_addr = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    if (out_free) begin
                        o_cmd.out_round = 1'b1;
                        n_out_valid     = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = S_HOLD;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_cnt      = r_cnt - 1'b1;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    o_cmd.out_hold = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sbd_datapath.sv
// datapath: round key store, block register and output register
`default_nettype none

module sbd_datapath #(
    parameter int NUM_ROUNDS = 10,
    localparam int AW = $clog2(NUM_ROUNDS + 1)
) (
    input  wire logic                        i_clk,
    input  wire sbd_pkg::t_dp_cmd            i_cmd,
    input  wire logic                        i_wr_en,
    input  wire logic [AW-1:0]               i_wr_addr,
    input  wire logic [AW-1:0]               i_rd_addr,
    input  wire logic [sbd_pkg::BLOCK_W-1:0] i_key_value,
    input  wire logic [sbd_pkg::BLOCK_W-1:0] i_ciphertext,
    output logic      [sbd_pkg::BLOCK_W-1:0] o_plaintext
);

    sbd_pkg::t_block r_blk, n_blk;
    sbd_pkg::t_block r_out, n_out;
    sbd_pkg::t_block rd_key;
    sbd_pkg::t_block round_val;

    sbd_ram #(
        .WIDTH (sbd_pkg::BLOCK_W),
        .DEPTH (NUM_ROUNDS + 1)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_addr),
        .i_wdata (i_key_value),
        .i_raddr (i_rd_addr),
        .o_rdata (rd_key)
    );

    assign round_val = sbd_pkg::inv_round(r_blk) ^ rd_key;

    always_comb begin
        n_blk = r_blk;
        n_out = r_out;
        if (i_cmd.cap_ct) begin
            n_blk = i_ciphertext;
        end else if (i_cmd.whiten) begin
            n_blk = r_blk ^ rd_key;
        end else if (i_cmd.step) begin
            n_blk = round_val;
        end
        if (i_cmd.out_round) begin
            n_out = round_val;
        end else if (i_cmd.out_hold) begin
            n_out = r_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_out <= n_out;
    end

    assign o_plaintext = r_out;

endmodule

`default_nettype wire

>>> rtl/spn_block_decrypt_24bit.sv
// top level of the 24-bit spn block decrypter
// usage:
//  - i_in_ch carries items with a command bit: a load-key item writes key_value
//    into round key slot key_index (slots above NUM_ROUNDS are ignored) and
//    gives no result; a decrypt item turns ciphertext into one plaintext item
//  - o_out_ch carries the plaintext items, in order, one per decrypt item
//  - a load-key item does not hold the input; a decrypt item holds it while
//    it is taken, then during the whitening xor with the last key, then
//    through the inverse rounds one at a time, as set by the single round unit
//    and the one read port of the key ram
//  - the result is valid right after the last round; the next item may be
//    accepted while that result still waits in the output register
//  - if the receiver stalls with a result still waiting, the following block
//    finishes its rounds and parks until the output register frees up
//  - every slot must be loaded before a decrypt uses it; the key ram is not
//    cleared by reset
//  - reset is synchronous and active low: it drops any item in flight and
//    any waiting result, but keeps loaded keys
`default_nettype none

module spn_block_decrypt_24bit #(
    parameter int NUM_ROUNDS = 10
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sbd_in_if.sink     i_in_ch,
    sbd_out_if.source  o_out_ch
);

    localparam int AW = $clog2(NUM_ROUNDS + 1);

    sbd_pkg::t_dp_cmd dp_cmd;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    // sequencing, handshakes and key addressing
    sbd_ctrl #(
        .NUM_ROUNDS (NUM_ROUNDS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_ch.valid),
        .i_in_command (i_in_ch.command),
        .i_key_index  (i_in_ch.key_index),
        .o_in_ready   (i_in_ch.ready),
        .o_out_valid  (o_out_ch.valid),
        .i_out_ready  (o_out_ch.ready),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_rd_addr    (rd_addr),
        .o_cmd        (dp_cmd)
    );

    // key store, round unit and output register
    sbd_datapath #(
        .NUM_ROUNDS (NUM_ROUNDS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_cmd        (dp_cmd),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_rd_addr    (rd_addr),
        .i_key_value  (i_in_ch.key_value),
        .i_ciphertext (i_in_ch.ciphertext),
        .o_plaintext  (o_out_ch.plaintext)
    );

endmodule

`default_nettype wire

>>> tb/sbd_checker.sv
`timescale 1ns / 100ps
// plaintext predictor and scoreboard that watch both channels of the block decrypter

module sbd_checker #(
    parameter int NUM_ROUNDS = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sbd_in_if    i_in_ch,
    sbd_out_if   i_out_ch,
    output int   o_fail_count,
    output int   o_pending
);

    // inverse s-box, indexed by the substituted nibble
    localparam logic [3:0] PLAIN_NIBBLE [16] = '{
        4'h5, 4'he, 4'hf, 4'h8, 4'hc, 4'h1, 4'h2, 4'hd,
        4'hb, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'ha
    };

    sbd_pkg::t_block round_keys [NUM_ROUNDS+1];
    sbd_pkg::t_block plaintext_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // source bit i lands on bit 4*(i mod 6) + i/6
    function automatic sbd_pkg::t_block decipher(input sbd_pkg::t_block ct);
        sbd_pkg::t_block s;
        sbd_pkg::t_block p;
        s = ct ^ round_keys[NUM_ROUNDS];
        for (int r = NUM_ROUNDS - 1; r >= 0; r--) begin
            p = '0;
            for (int i = 0; i < sbd_pkg::BLOCK_W; i++) begin
                p[4 * (i % 6) + i / 6] = s[i];
            end
            for (int n = 0; n < sbd_pkg::BLOCK_W / 4; n++) begin
                s[4*n +: 4] = PLAIN_NIBBLE[p[4*n +: 4]];
            end
            s = s ^ round_keys[r];
        end
        return s;
    endfunction

    task automatic report_failure(input string msg);
        if (o_fail_count < 10) begin
            $display("%0t: %s", $realtime, msg);
        end
        o_fail_count = o_fail_count + 1;
    endtask

    always @(posedge i_clk) begin
        sbd_pkg::t_block want;
        if (i_rst_n) begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                if (i_in_ch.command == sbd_pkg::CMD_LOAD_KEY) begin
                    // slots past the last round are dropped by the block
                    if (i_in_ch.key_index <= NUM_ROUNDS) begin
                        round_keys[i_in_ch.key_index] = i_in_ch.key_value;
                    end
                end else begin
                    plaintext_q.push_back(decipher(i_in_ch.ciphertext));
                end
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (plaintext_q.size() == 0) begin
                    report_failure($sformatf("unexpected plaintext %06h",
                                             i_out_ch.plaintext));
                end else begin
                    want = plaintext_q.pop_front();
                    if (i_out_ch.plaintext !== want) begin
                        report_failure($sformatf("plaintext expected %06h got %06h",
                                                 want, i_out_ch.plaintext));
                    end
                end
            end
            o_pending = plaintext_q.size();
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// top of the block decrypter bench: clock, reset, item stimulus, receiver stalls, verdict

module tb;

    localparam int NUM_ROUNDS    = 10;
    localparam int ITEM_TARGET   = 1650;
    // generous bound on draining the last results
    localparam int DRAIN_LIMIT   = 4000;
    // settle time: three times the span for which a decrypt holds the input
    localparam int SETTLE_CYCLES = 3 * (NUM_ROUNDS + 2);

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sbd_in_if  in_ch ();
    sbd_out_if out_ch ();

    int fail_count;
    int pending;

    // items left in the current sender burst
    int burst_left = 0;

    spn_block_decrypt_24bit #(
        .NUM_ROUNDS (NUM_ROUNDS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    sbd_checker #(
        .NUM_ROUNDS (NUM_ROUNDS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns period
    always #2 i_clk = ~i_clk;

    // hard stop in case the block hangs
    initial begin
        #4000000;
        $display("spn_block_decrypt_24bit: mismatch");
        $finish;
    end

    // block values biased toward all zeros and all ones
    function automatic sbd_pkg::t_block pick_block();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return sbd_pkg::t_block'($urandom);
        endcase
    endfunction

    // offer one item from a falling edge and hold it until the handshake,
    // then either keep the burst going or open a gap with valid low
    task automatic send_item(input logic cmd,
                             input logic [sbd_pkg::KEY_INDEX_W-1:0] idx,
                             input sbd_pkg::t_block kv, input sbd_pkg::t_block ct);
        int gap;
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.key_index  <= idx;
        in_ch.key_value  <= kv;
        in_ch.ciphertext <= ct;
        do begin
            @(posedge i_clk);
        end while (!(in_ch.valid && in_ch.ready));
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // now and then a long burst with no idling at all
            if ($urandom_range(0, 7) == 0) begin
                gap        = 0;
                burst_left = $urandom_range(100, 200);
            end else begin
                gap        = $urandom_range(0, 8);
                burst_left = $urandom_range(0, 40);
            end
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic load_key(input logic [sbd_pkg::KEY_INDEX_W-1:0] idx,
                            input sbd_pkg::t_block kv);
        send_item(sbd_pkg::CMD_LOAD_KEY, idx, kv, pick_block());
    endtask

    task automatic decrypt(input sbd_pkg::t_block ct);
        send_item(sbd_pkg::CMD_DECRYPT, sbd_pkg::KEY_INDEX_W'($urandom), pick_block(), ct);
    endtask

    // receiver: a randomly redrawn stall pattern, plus two long hold-offs
    // during which the sender keeps offering so the block backs up
    initial begin : receiver
        int rx_cycle;
        int mode;
        int hold_left;
        rx_cycle     = 0;
        mode         = 0;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_cycle % 97 == 0) begin
                mode = $urandom_range(0, 3);
            end
            if (rx_cycle == 3000 || rx_cycle == 25000) begin
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= ((rx_cycle / 3) % 2 == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int counted;
        int wait_cycles;
        logic cmd;
        logic [sbd_pkg::KEY_INDEX_W-1:0] idx;
        sbd_pkg::t_block kv;
        sbd_pkg::t_block ct;

        in_ch.valid      = 1'b0;
        in_ch.command    = sbd_pkg::CMD_LOAD_KEY;
        in_ch.key_index  = '0;
        in_ch.key_value  = '0;
        in_ch.ciphertext = '0;

        // synchronous reset held low, then released on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: fill every key slot first, the store is undefined until written
        load_key(4'd0, '0);
        load_key(4'd1, 24'h800001);
        for (int s = 2; s < NUM_ROUNDS; s++) begin
            load_key(sbd_pkg::KEY_INDEX_W'(s), sbd_pkg::t_block'($urandom));
        end
        load_key(sbd_pkg::KEY_INDEX_W'(NUM_ROUNDS), '1);

        // loads past the last slot must leave the keys alone
        load_key(sbd_pkg::KEY_INDEX_W'(NUM_ROUNDS + 1), '0);
        load_key(4'd15, '1);

        decrypt('0);
        decrypt('1);
        decrypt(24'h0f0f0f);
        decrypt(24'hf0f0f0);
        decrypt(sbd_pkg::t_block'($urandom));

        // swap the whitening key and the first round key extremes
        load_key(sbd_pkg::KEY_INDEX_W'(NUM_ROUNDS), '0);
        load_key(4'd0, '1);
        decrypt('1);
        decrypt('0);

        load_key(4'd5, sbd_pkg::t_block'($urandom));
        decrypt(sbd_pkg::t_block'($urandom));
        counted = 22;

        // random part: mostly decrypts, key reloads mixed in at any slot
        while (counted < ITEM_TARGET) begin
            cmd = ($urandom_range(0, 99) < 85) ? sbd_pkg::CMD_DECRYPT
                                               : sbd_pkg::CMD_LOAD_KEY;
            idx = sbd_pkg::KEY_INDEX_W'($urandom);
            kv  = pick_block();
            ct  = pick_block();
            send_item(cmd, idx, kv, ct);
            // ignored loads do not count
            if (cmd == sbd_pkg::CMD_DECRYPT || idx <= NUM_ROUNDS) begin
                counted++;
            end
        end
        in_ch.valid <= 1'b0;

        // drain what is still expected, then let the block settle
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("spn_block_decrypt_24bit: match");
        end else begin
            $display("spn_block_decrypt_24bit: mismatch");
        end
        $finish;
    end

endmodule
